// ===== design/dtfe_pkg.sv =====
`timescale 1ns / 1ps

package dtfe_pkg;

  // Item modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ADJUST = 2'd1;
  localparam logic [1:0] MODE_NEXT   = 2'd2;

  // Cursor fields
  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_AMPM   = 3'd5;

  // Year range and step limit
  localparam logic [13:0]       YEAR_LOW    = 14'd2000;
  localparam logic [13:0]       YEAR_HIGH   = 14'd2099;
  localparam logic signed [7:0] DELTA_LIMIT = 8'sd60;

  // Default date and time
  localparam logic [13:0] DEF_YEAR   = 14'd2026;
  localparam logic [3:0]  DEF_MONTH  = 4'd1;
  localparam logic [4:0]  DEF_DAY    = 5'd1;
  localparam logic [4:0]  DEF_HOUR   = 5'd12;
  localparam logic [5:0]  DEF_MINUTE = 6'd0;

  // Wrap moduli and calendar constants
  localparam logic [5:0]  MONTHS_PER_YEAR  = 6'd12;
  localparam logic [5:0]  HOURS_PER_DAY    = 6'd24;
  localparam logic [5:0]  HOURS_PER_HALF   = 6'd12;
  localparam logic [5:0]  MINUTES_PER_HOUR = 6'd60;
  localparam logic [4:0]  HALF_DAY         = 5'd12;
  localparam logic [13:0] LEAP_CYCLE       = 14'd400;
  localparam logic [1:0]  LEAP_LAST_PHASE  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic signed [7:0] delta;
    logic              seed_valid;
    logic [13:0]       seed_year;
    logic [3:0]        seed_month;
    logic [4:0]        seed_day;
    logic [4:0]        seed_hour;
    logic [5:0]        seed_minute;
  } in_word_t;

  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [2:0]  cursor;
    logic        changed;
    logic        at_last;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       accept;
    logic       leap_step;
    logic [1:0] leap_phase;
    logic       wrap_init;
    logic       wrap_step;
    logic       commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic wrap_ok;
  } sts_t;

  // Days in a month; an out-of-range month counts as 31 days
  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // One restoring step of year mod 400: subtract 400 * 2^k if it fits
  function automatic logic [13:0] leap_reduce(input logic [13:0] r, input logic [2:0] k);
    logic [13:0] sub;
    sub = LEAP_CYCLE << k;
    return (r >= sub) ? (r - sub) : r;
  endfunction

  // Gregorian leap rule from the low year bits and the year mod 400
  function automatic logic is_leap(input logic [1:0] y_lo, input logic [13:0] rem400);
    return (y_lo == 2'd0) && (rem400 != 14'd100) && (rem400 != 14'd200) &&
           (rem400 != 14'd300);
  endfunction

  // Clamp a day into 1 .. month length
  function automatic logic [4:0] fix_day(input logic [4:0] d, input logic [4:0] mx);
    logic [4:0] r;
    if (d > mx) begin
      r = mx;
    end else if (d == 5'd0) begin
      r = 5'd1;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// ===== design/dtfe_ctrl.sv =====
`timescale 1ns / 1ps

module dtfe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  dtfe_pkg::sts_t sts,
  output dtfe_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LEAP = 4'b0010,
    S_WSET = 4'b0100,
    S_WRAP = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  // Sequence one word: leap reduction, wrap setup, wrap steps, commit
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    cmd            = '0;
    cmd.leap_phase = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          phase_nxt  = 2'd0;
          state_nxt  = S_LEAP;
        end
      end
      S_LEAP: begin
        cmd.leap_step = 1'b1;
        phase_nxt     = phase_r + 2'd1;
        if (phase_r == dtfe_pkg::LEAP_LAST_PHASE) begin
          state_nxt = S_WSET;
        end
      end
      S_WSET: begin
        cmd.wrap_init = 1'b1;
        state_nxt     = S_WRAP;
      end
      S_WRAP: begin
        priority if (!sts.wrap_ok) begin
          cmd.wrap_step = 1'b1;
        end else if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          // hold until the output register frees
          state_nxt = S_WRAP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Track the output register
  always_comb begin
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/dtfe_dp.sv =====
`timescale 1ns / 1ps

module dtfe_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  dtfe_pkg::cmd_t      cmd,
  output dtfe_pkg::sts_t      sts,
  input  dtfe_pkg::in_word_t  in_data,
  input  logic                cfg_we,
  input  logic                cfg_data,
  output dtfe_pkg::out_word_t out_data
);

  // Edited state and mode register
  logic        twelve_r;
  logic [13:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [2:0]  field_sel_r, field_sel_nxt;

  // Per-word working registers
  dtfe_pkg::in_word_t  item_r;
  logic signed [7:0]   sd_r, sd_nxt;
  logic [13:0]         cy_r, cy_nxt;
  logic [13:0]         yrem_r;
  logic signed [7:0]   wv_r, wv_nxt, wv_step;
  logic [5:0]          wn_r, wn_nxt;
  dtfe_pkg::out_word_t out_r, out_nxt;

  logic signed [15:0] yr_sum;
  logic [13:0]        yr_clamp;
  logic [2:0]         k_hi, k_lo;
  logic               leap_w;
  logic [4:0]         h12;
  logic signed [7:0]  wn_s;
  logic               seed_ok;
  logic [2:0]         last_fld;
  logic               changed, at_last;

  assign leap_w = dtfe_pkg::is_leap(cy_r[1:0], yrem_r);
  assign h12    = (hour_r >= dtfe_pkg::HALF_DAY) ? (hour_r - dtfe_pkg::HALF_DAY) : hour_r;
  assign wn_s   = $signed({2'b00, wn_r});
  assign sts.wrap_ok = !wv_r[7] && (wv_r < wn_s);
  assign out_data    = out_r;

  // Saturate the step and pick the year whose leap status is needed
  always_comb begin
    priority if (in_data.delta > dtfe_pkg::DELTA_LIMIT) begin
      sd_nxt = dtfe_pkg::DELTA_LIMIT;
    end else if (in_data.delta < -dtfe_pkg::DELTA_LIMIT) begin
      sd_nxt = -dtfe_pkg::DELTA_LIMIT;
    end else begin
      sd_nxt = in_data.delta;
    end
    yr_sum = $signed({2'b00, year_r}) + 16'(sd_nxt);
    priority if (yr_sum < $signed({2'b00, dtfe_pkg::YEAR_LOW})) begin
      yr_clamp = dtfe_pkg::YEAR_LOW;
    end else if (yr_sum > $signed({2'b00, dtfe_pkg::YEAR_HIGH})) begin
      yr_clamp = dtfe_pkg::YEAR_HIGH;
    end else begin
      yr_clamp = yr_sum[13:0];
    end
    priority if (in_data.mode == dtfe_pkg::MODE_LOAD) begin
      cy_nxt = in_data.seed_year;
    end else if (in_data.mode == dtfe_pkg::MODE_ADJUST &&
                 field_sel_r == dtfe_pkg::FLD_YEAR && sd_nxt != 8'sd0) begin
      cy_nxt = yr_clamp;
    end else begin
      cy_nxt = year_r;
    end
  end

  // Two mod-400 steps per cycle: shifts 5,4 then 3,2 then 1,0
  assign k_hi = 3'd5 - {cmd.leap_phase, 1'b0};
  assign k_lo = k_hi - 3'd1;

  // Set up the wrapped value and its modulus for the selected field
  always_comb begin
    wv_nxt = 8'sd0;
    wn_nxt = dtfe_pkg::MONTHS_PER_YEAR;
    if (item_r.mode == dtfe_pkg::MODE_ADJUST && sd_r != 8'sd0) begin
      unique case (field_sel_r)
        dtfe_pkg::FLD_MONTH: begin
          wv_nxt = $signed({4'b0000, month_r}) - 8'sd1 + sd_r;
          wn_nxt = dtfe_pkg::MONTHS_PER_YEAR;
        end
        dtfe_pkg::FLD_DAY: begin
          wv_nxt = $signed({3'b000, day_r}) - 8'sd1 + sd_r;
          wn_nxt = {1'b0, dtfe_pkg::month_days(leap_w, month_r)};
        end
        dtfe_pkg::FLD_HOUR: begin
          if (twelve_r) begin
            wv_nxt = $signed({3'b000, h12}) + sd_r;
            wn_nxt = dtfe_pkg::HOURS_PER_HALF;
          end else begin
            wv_nxt = $signed({3'b000, hour_r}) + sd_r;
            wn_nxt = dtfe_pkg::HOURS_PER_DAY;
          end
        end
        dtfe_pkg::FLD_MINUTE: begin
          wv_nxt = $signed({2'b00, minute_r}) + sd_r;
          wn_nxt = dtfe_pkg::MINUTES_PER_HOUR;
        end
        default: begin
          wv_nxt = 8'sd0;
        end
      endcase
    end
  end

  // Add or subtract the modulus once per step
  always_comb begin
    priority if (wv_r[7]) begin
      wv_step = wv_r + wn_s;
    end else if (wv_r >= wn_s) begin
      wv_step = wv_r - wn_s;
    end else begin
      wv_step = wv_r;
    end
  end

  // Compute the new state and the result word
  always_comb begin
    year_nxt      = year_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    field_sel_nxt = field_sel_r;
    changed       = 1'b0;
    at_last       = 1'b0;
    last_fld      = twelve_r ? dtfe_pkg::FLD_AMPM : dtfe_pkg::FLD_MINUTE;
    seed_ok = item_r.seed_valid && item_r.seed_month >= 4'd1 &&
              item_r.seed_month <= 4'd12 && item_r.seed_day >= 5'd1 &&
              item_r.seed_day <= dtfe_pkg::month_days(leap_w, item_r.seed_month) &&
              item_r.seed_hour < 5'd24 && item_r.seed_minute < 6'd60 &&
              item_r.seed_year >= dtfe_pkg::YEAR_LOW;
    unique case (item_r.mode)
      dtfe_pkg::MODE_LOAD: begin
        field_sel_nxt = dtfe_pkg::FLD_YEAR;
        if (seed_ok) begin
          year_nxt   = item_r.seed_year;
          month_nxt  = item_r.seed_month;
          day_nxt    = item_r.seed_day;
          hour_nxt   = item_r.seed_hour;
          minute_nxt = item_r.seed_minute;
        end else begin
          year_nxt   = dtfe_pkg::DEF_YEAR;
          month_nxt  = dtfe_pkg::DEF_MONTH;
          day_nxt    = dtfe_pkg::DEF_DAY;
          hour_nxt   = dtfe_pkg::DEF_HOUR;
          minute_nxt = dtfe_pkg::DEF_MINUTE;
        end
      end
      dtfe_pkg::MODE_ADJUST: begin
        if (sd_r != 8'sd0) begin
          unique case (field_sel_r)
            dtfe_pkg::FLD_YEAR: begin
              year_nxt = cy_r;
              day_nxt  = dtfe_pkg::fix_day(day_r, dtfe_pkg::month_days(leap_w, month_r));
            end
            dtfe_pkg::FLD_MONTH: begin
              month_nxt = wv_r[3:0] + 4'd1;
              day_nxt   = dtfe_pkg::fix_day(day_r, dtfe_pkg::month_days(leap_w, month_nxt));
            end
            dtfe_pkg::FLD_DAY: begin
              day_nxt = wv_r[4:0] + 5'd1;
            end
            dtfe_pkg::FLD_HOUR: begin
              if (twelve_r) begin
                hour_nxt = wv_r[4:0] +
                           ((hour_r >= dtfe_pkg::HALF_DAY) ? dtfe_pkg::HALF_DAY : 5'd0);
              end else begin
                hour_nxt = wv_r[4:0];
              end
            end
            dtfe_pkg::FLD_MINUTE: begin
              minute_nxt = wv_r[5:0];
            end
            dtfe_pkg::FLD_AMPM: begin
              // flip the half-day on an odd step
              if (sd_r[0]) begin
                hour_nxt = (hour_r >= dtfe_pkg::HALF_DAY) ? (hour_r - dtfe_pkg::HALF_DAY) :
                                                            (hour_r + dtfe_pkg::HALF_DAY);
              end
            end
            default: begin
              hour_nxt = hour_r;
            end
          endcase
        end
        changed = (year_nxt != year_r) || (month_nxt != month_r) || (day_nxt != day_r) ||
                  (hour_nxt != hour_r) || (minute_nxt != minute_r);
      end
      dtfe_pkg::MODE_NEXT: begin
        if (field_sel_r >= last_fld) begin
          field_sel_nxt = last_fld;
          at_last       = 1'b1;
        end else begin
          field_sel_nxt = field_sel_r + 3'd1;
        end
      end
      default: begin
        field_sel_nxt = field_sel_r;
      end
    endcase
    out_nxt.cur_year   = year_nxt;
    out_nxt.cur_month  = month_nxt;
    out_nxt.cur_day    = day_nxt;
    out_nxt.cur_hour   = hour_nxt;
    out_nxt.cur_minute = minute_nxt;
    out_nxt.cursor     = field_sel_nxt;
    out_nxt.changed    = changed;
    out_nxt.at_last    = at_last;
  end

  // Edited state and mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      twelve_r    <= 1'b0;
      year_r      <= dtfe_pkg::DEF_YEAR;
      month_r     <= dtfe_pkg::DEF_MONTH;
      day_r       <= dtfe_pkg::DEF_DAY;
      hour_r      <= dtfe_pkg::DEF_HOUR;
      minute_r    <= dtfe_pkg::DEF_MINUTE;
      field_sel_r <= dtfe_pkg::FLD_YEAR;
    end else begin
      if (cfg_we) begin
        twelve_r <= cfg_data;
      end
      if (cmd.commit) begin
        year_r      <= year_nxt;
        month_r     <= month_nxt;
        day_r       <= day_nxt;
        hour_r      <= hour_nxt;
        minute_r    <= minute_nxt;
        field_sel_r <= field_sel_nxt;
      end
    end
  end

  // Working registers and the result word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
      sd_r   <= sd_nxt;
      cy_r   <= cy_nxt;
      yrem_r <= cy_nxt;
    end
    if (cmd.leap_step) begin
      yrem_r <= dtfe_pkg::leap_reduce(dtfe_pkg::leap_reduce(yrem_r, k_hi), k_lo);
    end
    if (cmd.wrap_init) begin
      wv_r <= wv_nxt;
      wn_r <= wn_nxt;
    end else if (cmd.wrap_step) begin
      wv_r <= wv_step;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== design/date_time_field_editor.sv =====
`timescale 1ns / 1ps

// Date and time field editor. Each input word loads a seed clock, adjusts the
// selected field by a saturated step, or moves the cursor, and yields exactly
// one result word. One word at a time is processed: input is stalled from
// acceptance until the commit. Leap steps reduce the year mod 400 for the
// leap rule (two conditional subtractions a cycle), a set-up step prepares
// the field wrap, and the wrap unit then adds or subtracts the modulus once a
// cycle (up to five steps for a 12-way field) before the result is committed.
// A finished result sits in an output register, so the commit only waits if
// the previous result is still held there. The 12-hour mode register is
// always ready and must only be written while no word is in flight.
module date_time_field_editor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtfe_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dtfe_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  dtfe_pkg::cmd_t cmd;
  dtfe_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  dtfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtfe_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

  // Accepted word blocks further input while it is worked on
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in flight");

  // Never overwrite a result that is still waiting
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result overwritten before delivery");

  // Delivered date and time stay in their ranges
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cur_month >= 4'd1 && out_data.cur_month <= 4'd12 &&
                   out_data.cur_day >= 5'd1 && out_data.cur_hour < 5'd24 &&
                   out_data.cur_minute < 6'd60 && out_data.cursor <= dtfe_pkg::FLD_AMPM))
    else $error("result field out of range");

endmodule
